@@ src/agks_pkg.sv @@
// Package for the ADC/GPIO key scanner with long press.
// Holds shared constants, command codes and the cell/token types.
package agks_pkg;

    localparam int NUM_KEYS_DEF    = 8;
    localparam int SAMPLE_BITS_DEF = 10;
    localparam int RESULT_CAP      = 16;
    localparam int CNT_W           = 5;

    localparam logic [1:0] CMD_ADC    = 2'd0;
    localparam logic [1:0] CMD_EDGE   = 2'd1;
    localparam logic [1:0] CMD_TICK   = 2'd2;
    localparam logic [1:0] CMD_CENTER = 2'd3;

    localparam logic [2:0] REG_DRIFT  = 3'd0;
    localparam logic [2:0] REG_LONG   = 3'd1;
    localparam logic [2:0] REG_GAP    = 3'd2;
    localparam logic [2:0] REG_GPIO   = 3'd3;
    localparam logic [2:0] REG_ALOW   = 3'd4;
    localparam logic [2:0] REG_LPMASK = 3'd5;
    localparam logic [2:0] REG_WAKE   = 3'd6;

    // Per-key configuration handed to every cell
    typedef struct packed {
        logic [9:0]  drift;
        logic [15:0] lp;
        logic [16:0] per;
        logic        is_gpio;
        logic        act_low;
        logic        is_long;
        logic        wake;
    } t_cell_cfg;

    // Command token moving down the chain
    typedef struct packed {
        logic       vld;
        logic [1:0] cmd;
        logic [9:0] sample;
        logic       sel;
        logic       susp;
        logic [9:0] center;
        logic       lvl;
    } t_token;

    // Events one cell produces for its token
    typedef struct packed {
        logic [1:0] n;
        logic       e0_long;
        logic       e0_pr;
        logic       e1_long;
        logic       e1_pr;
    } t_cell_ev;

endpackage

@@ src/agks_cell.sv @@
// One key cell: holds a key's state and runs the token handed to it.
// Depends on agks_pkg.
module agks_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  agks_pkg::t_cell_cfg i_cfg,
    input  agks_pkg::t_token    i_tok,
    output agks_pkg::t_cell_ev  o_ev
);
    import agks_pkg::*;

    logic [9:0]  r_center, n_center;
    logic        r_hit, n_hit, r_level, n_level, r_armed, n_armed;
    logic        r_hold, n_hold, r_past, n_past;
    logic [15:0] r_sph, n_sph;
    logic [16:0] r_pph, n_pph;
    logic [10:0] w_hi, w_c;
    logic [11:0] w_lo;
    logic        w_st;

    always_comb begin
        n_center = r_center; n_hit = r_hit; n_level = r_level; n_armed = r_armed;
        n_hold = r_hold; n_past = r_past; n_sph = r_sph; n_pph = r_pph;
        o_ev = '0;
        w_c  = {1'b0, r_center};
        w_hi = w_c + {1'b0, i_cfg.drift};
        w_lo = {1'b0, w_c} - {2'b0, i_cfg.drift};
        w_st = i_cfg.is_gpio ? (i_tok.lvl ^ i_cfg.act_low) : r_hit;
        if (i_tok.vld) begin
            case (i_tok.cmd)
                CMD_ADC: begin
                    if (r_center != '0) begin
                        // strict window; lower bound is signed
                        n_hit = ({1'b0, i_tok.sample} < w_hi) &&
                                (w_lo[11] || ({2'b0, i_tok.sample} > w_lo));
                        if (r_level != n_hit) n_armed = 1'b1;
                    end
                end
                CMD_EDGE: begin
                    if (i_tok.sel && i_cfg.is_gpio) begin
                        if (i_cfg.wake && i_tok.susp) begin
                            n_level = 1'b1;
                            o_ev.n = 2'd1; o_ev.e0_pr = 1'b1;
                        end
                        n_hold = 1'b0; n_sph = '0; n_pph = '0; n_past = 1'b0;
                        n_armed = 1'b1;
                    end
                end
                CMD_TICK: begin
                    if (r_armed) begin
                        n_armed = 1'b0;
                        if (i_cfg.is_long) begin
                            if (w_st) begin
                                if (r_hold) begin
                                    if (r_pph == '0) begin
                                        o_ev.n = 2'd1; o_ev.e0_long = 1'b1;
                                    end else if (r_sph == '0) begin
                                        o_ev.n = 2'd1; o_ev.e0_long = 1'b1;
                                        o_ev.e0_pr = 1'b1;
                                    end
                                end
                                if (r_past || (r_hold && r_sph == '0)) n_past = 1'b1;
                                n_hold = 1'b1;
                                n_sph = ({1'b0, r_sph} + 17'd1 >= {1'b0, i_cfg.lp}) ?
                                        '0 : r_sph + 16'd1;
                                n_pph = ({1'b0, r_pph} + 18'd1 >= {1'b0, i_cfg.per}) ?
                                        '0 : r_pph + 17'd1;
                                n_armed = 1'b1;
                            end else if (!r_past) begin
                                n_hold = 1'b0; n_sph = '0; n_pph = '0;
                                o_ev.n = 2'd2; o_ev.e0_pr = 1'b1;
                            end else if (r_level) begin
                                o_ev.n = 2'd1; o_ev.e0_long = 1'b1;
                            end
                            n_level = w_st;
                        end else begin
                            if (r_level != w_st) begin
                                n_level = w_st;
                                o_ev.n = 2'd1; o_ev.e0_pr = w_st;
                            end
                            if (w_st) n_armed = 1'b1;
                        end
                    end
                end
                CMD_CENTER: begin
                    if (i_tok.sel) n_center = i_tok.center;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center <= '0; r_hit <= 1'b0; r_level <= 1'b0; r_armed <= 1'b0;
            r_hold <= 1'b0; r_past <= 1'b0; r_sph <= '0; r_pph <= '0;
        end else begin
            r_center <= n_center; r_hit <= n_hit; r_level <= n_level;
            r_armed <= n_armed; r_hold <= n_hold; r_past <= n_past;
            r_sph <= n_sph; r_pph <= n_pph;
        end
    end
endmodule

@@ src/adc_gpio_key_scanner_long_press_core.sv @@
// Key scanner with long press: one input transaction walks a chain of key cells.
// Cell k runs the token at step k of the walk; events go to the FIFO as cells produce them.
// One item at a time: a new item is taken only once the token walk over the cell chain
// is over and the event FIFO has drained.
// Reset (synchronous, active low) clears all key state; registers take defaults.
// Depends on agks_pkg and agks_cell.
module adc_gpio_key_scanner_long_press_core #(
    parameter int NUM_KEYS    = agks_pkg::NUM_KEYS_DEF,
    parameter int SAMPLE_BITS = agks_pkg::SAMPLE_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata: cmd[1:0], sample[11:2], key_index[14:12], gpio_levels[22:15],
    //        suspended[23], center[33:24], zero fill to 40 bits
    input  logic [39:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata: event_key[2:0], long_code[3], pressed[4], zero fill to 8 bits
    output logic [7:0]  m_axis_tdata,
    output logic        m_axis_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import agks_pkg::*;

    localparam int KW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
    localparam int SW = (NUM_KEYS + 1 > 1) ? $clog2(NUM_KEYS + 1) : 1;
    localparam logic [9:0] SMASK = 10'((32'd1 << SAMPLE_BITS) - 32'd1);

    // configuration registers
    logic [9:0]  r_drift;
    logic [15:0] r_lp, r_gap;
    logic [7:0]  r_gpio, r_alow, r_lpm, r_wake;
    logic [2:0]  w_reg;

    assign pready = 1'b1;
    assign w_reg  = paddr[4:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drift <= 10'd70; r_lp <= 16'd100; r_gap <= 16'd50;
            r_gpio <= '0; r_alow <= '0; r_lpm <= '0; r_wake <= '0;
        end else if (psel && penable && pwrite) begin
            case (w_reg)
                REG_DRIFT:  r_drift <= pwdata[9:0];
                REG_LONG:   r_lp    <= pwdata[15:0];
                REG_GAP:    r_gap   <= pwdata[15:0];
                REG_GPIO:   r_gpio  <= pwdata[7:0];
                REG_ALOW:   r_alow  <= pwdata[7:0];
                REG_LPMASK: r_lpm   <= pwdata[7:0];
                REG_WAKE:   r_wake  <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // read back
    always_comb begin
        case (w_reg)
            REG_DRIFT:  prdata = {22'd0, r_drift};
            REG_LONG:   prdata = {16'd0, r_lp};
            REG_GAP:    prdata = {16'd0, r_gap};
            REG_GPIO:   prdata = {24'd0, r_gpio};
            REG_ALOW:   prdata = {24'd0, r_alow};
            REG_LPMASK: prdata = {24'd0, r_lpm};
            REG_WAKE:   prdata = {24'd0, r_wake};
            default:    prdata = '0;
        endcase
    end

    logic [15:0] w_lp_eff;
    logic [16:0] w_per;
    assign w_lp_eff = (r_lp == '0) ? 16'd1 : r_lp;
    assign w_per    = {1'b0, w_lp_eff} + {1'b0, r_gap};

    // input capture and token chain
    logic        r_busy;
    logic [SW-1:0] r_step;
    logic [1:0]  r_cmd;
    logic [9:0]  r_sample, r_cen;
    logic [2:0]  r_idx;
    logic [7:0]  r_lvls;
    logic        r_susp;
    t_token      r_tok [NUM_KEYS];
    t_token      w_tok_in [NUM_KEYS];
    t_cell_ev    w_ev [NUM_KEYS];
    logic        w_take;

    // event FIFO
    localparam int FD = RESULT_CAP;
    logic [4:0]  r_fifo [FD];
    logic [CNT_W-1:0] r_wp, r_rp, r_cnt;
    logic [CNT_W-1:0] r_nev;
    logic        w_pop;

    assign s_axis_tready = !r_busy && (r_cnt == '0);
    assign w_take = s_axis_tvalid && s_axis_tready;

    genvar g;
    generate
        for (g = 0; g < NUM_KEYS; g++) begin : g_cell
            t_cell_cfg w_cfg;
            always_comb begin
                w_cfg.drift   = r_drift;
                w_cfg.lp      = w_lp_eff;
                w_cfg.per     = w_per;
                w_cfg.is_gpio = (g < 8) ? r_gpio[g % 8] : 1'b0;
                w_cfg.act_low = (g < 8) ? r_alow[g % 8] : 1'b0;
                w_cfg.is_long = (g < 8) ? r_lpm[g % 8] : 1'b0;
                w_cfg.wake    = (g < 8) ? r_wake[g % 8] : 1'b0;
            end
            // token from the neighbor (or from the input registers for cell 0)
            if (g == 0) begin : g_head
                always_comb begin
                    w_tok_in[0].vld    = r_busy && (r_step == '0);
                    w_tok_in[0].cmd    = r_cmd;
                    w_tok_in[0].sample = r_sample;
                    w_tok_in[0].susp   = r_susp;
                    w_tok_in[0].center = r_cen;
                    w_tok_in[0].sel    = (r_idx == 3'd0);
                    w_tok_in[0].lvl    = r_lvls[0];
                end
            end else begin : g_link
                always_comb begin
                    w_tok_in[g]     = r_tok[g-1];
                    w_tok_in[g].sel = ({29'd0, r_idx} == 32'(g));
                    w_tok_in[g].lvl = (g < 8) ? r_lvls[g % 8] : 1'b0;
                end
            end
            agks_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_cfg   (w_cfg),
                .i_tok   (w_tok_in[g]),
                .o_ev    (w_ev[g])
            );
            // hand the token on
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) r_tok[g].vld <= 1'b0;
                else          r_tok[g] <= w_tok_in[g];
            end
        end
    endgenerate

    // find which cell holds the token this cycle
    t_cell_ev w_cur;
    logic [2:0] w_cur_key;
    always_comb begin
        w_cur = '0;
        w_cur_key = '0;
        for (int k = 0; k < NUM_KEYS; k++) begin
            if (w_tok_in[k].vld) begin
                w_cur = w_ev[k];
                w_cur_key = 3'(k);
            end
        end
    end

    logic w_done;
    assign w_done = r_busy && (r_step == SW'(NUM_KEYS));
    assign w_pop  = m_axis_tvalid && m_axis_tready;

    // push events, pop to the output
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0; r_step <= '0;
            r_wp <= '0; r_rp <= '0; r_cnt <= '0; r_nev <= '0;
        end else begin
            logic [CNT_W-1:0] v_wp, v_n;
            logic [CNT_W-1:0] v_cnt;
            v_wp = r_wp; v_n = r_nev; v_cnt = r_cnt;
            if (w_take) begin
                r_busy <= 1'b1; r_step <= '0; v_n = '0;
            end else if (r_busy) begin
                r_step <= r_step + SW'(1);
                if (w_done) begin
                    r_busy <= 1'b0;
                end
            end
            if (w_cur.n != 2'd0 && v_n < CNT_W'(RESULT_CAP)) begin
                v_wp = v_wp + CNT_W'(1); v_n = v_n + CNT_W'(1);
                v_cnt = v_cnt + CNT_W'(1);
            end
            if (w_cur.n == 2'd2 && v_n < CNT_W'(RESULT_CAP)) begin
                v_wp = v_wp + CNT_W'(1); v_n = v_n + CNT_W'(1);
                v_cnt = v_cnt + CNT_W'(1);
            end
            if (w_pop) begin
                r_rp <= (r_rp == CNT_W'(FD - 1)) ? '0 : r_rp + CNT_W'(1);
                v_cnt = v_cnt - CNT_W'(1);
            end
            r_wp <= v_wp; r_nev <= v_n; r_cnt <= v_cnt;
        end
    end

    // wrap-free write: 16 entries, 4-bit index from 5-bit pointer
    always_ff @(posedge i_clk) begin
        if (w_cur.n != 2'd0 && r_nev < CNT_W'(RESULT_CAP))
            r_fifo[r_wp[3:0]] <= {w_cur.e0_pr, w_cur.e0_long, w_cur_key};
        if (w_cur.n == 2'd2 && r_nev + CNT_W'(1) < CNT_W'(RESULT_CAP))
            r_fifo[4'(r_wp + CNT_W'(1))] <= {1'b0, 1'b0, w_cur_key};
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_cmd    <= s_axis_tdata[1:0];
            r_sample <= s_axis_tdata[11:2] & SMASK;
            r_idx    <= s_axis_tdata[14:12];
            r_lvls   <= s_axis_tdata[22:15];
            r_susp   <= s_axis_tdata[23];
            r_cen    <= s_axis_tdata[33:24] & SMASK;
        end
    end

    // show events only once the walk is over
    assign m_axis_tvalid = !r_busy && (r_cnt != '0);
    assign m_axis_tdata  = {3'd0, r_fifo[r_rp[3:0]]};
    assign m_axis_tlast  = (r_cnt == CNT_W'(1));

`ifndef SYNTHESIS
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !s_axis_tready) else $error("accepted while walking");
    a_cnt_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(RESULT_CAP)) else $error("event count over cap");
    a_one_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones({r_busy && r_step == '0, r_tok[0].vld}) <= 1)
        else $error("two tokens at head");
`endif
endmodule

@@ verif/agks_checker.sv @@
// Checker for the ADC/GPIO key scanner: snoops the input stream and the APB
// port, predicts the key events and compares them with the output stream.
// Depends on agks_pkg.
module agks_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [39:0] i_in_data,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [7:0]  i_out_data,
    input  logic        i_out_last,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic        i_pready,
    input  logic [4:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    output int          o_errors,
    output int          o_pending,
    output int          o_events_seen
);
    timeunit 1ns;
    timeprecision 1ps;
    import agks_pkg::*;

    localparam int KEYS = 8;

    typedef struct packed {
        logic [2:0] key;
        logic       lng;
        logic       pr;
        logic       last;
    } t_key_event;

    // shadow of the register file
    logic [9:0]  drift_win;
    logic [15:0] long_ticks;
    logic [15:0] gap_ticks;
    logic [7:0]  gpio_mask, alow_mask, long_mask, wake_mask;

    // shadow of the per-key state
    logic [9:0]  center_q  [KEYS];
    logic        hit_q     [KEYS];
    logic        level_q   [KEYS];
    logic        armed_q   [KEYS];
    logic        held_q    [KEYS];
    int          short_q   [KEYS];
    int          period_q  [KEYS];
    logic        past_q    [KEYS];

    t_key_event  item_events[$];
    t_key_event  expected_events[$];

    assign o_pending = expected_events.size();

    function automatic void add_event(int k, logic lng, logic pr);
        t_key_event ev;
        if (item_events.size() >= RESULT_CAP) return;
        ev.key  = k[2:0];
        ev.lng  = lng;
        ev.pr   = pr;
        ev.last = 1'b0;
        item_events.push_back(ev);
    endfunction

    function automatic void clear_hold(int k);
        held_q[k]   = 1'b0;
        short_q[k]  = 0;
        period_q[k] = 0;
        past_q[k]   = 1'b0;
    endfunction

    // long-press key at a debounce tick
    function automatic void tick_long(int k, logic st);
        int   lp;
        int   per;
        logic reached;
        lp  = (long_ticks == 0) ? 1 : int'(long_ticks);
        per = lp + int'(gap_ticks);
        if (st) begin
            if (held_q[k]) begin
                if (period_q[k] == 0) add_event(k, 1'b1, 1'b0);
                else if (short_q[k] == 0) add_event(k, 1'b1, 1'b1);
            end
            reached = past_q[k] || (held_q[k] && short_q[k] == 0);
            if (reached) past_q[k] = 1'b1;
            held_q[k]   = 1'b1;
            short_q[k]  = (short_q[k] + 1 >= lp) ? 0 : short_q[k] + 1;
            period_q[k] = (period_q[k] + 1 >= per) ? 0 : period_q[k] + 1;
            armed_q[k]  = 1'b1;
        end else begin
            if (!past_q[k]) begin
                clear_hold(k);
                add_event(k, 1'b0, 1'b1);
                add_event(k, 1'b0, 1'b0);
            end else if (level_q[k]) begin
                add_event(k, 1'b1, 1'b0);
            end
        end
        level_q[k] = st;
    endfunction

    function automatic void predict_scan(logic [39:0] d);
        logic [1:0] cmd;
        logic [9:0] sample;
        logic [2:0] idx;
        logic [7:0] lv;
        logic       susp;
        logic [9:0] cen;
        logic       st;
        int         c;
        int         w;
        cmd    = d[1:0];
        sample = d[11:2];
        idx    = d[14:12];
        lv     = d[22:15];
        susp   = d[23];
        cen    = d[33:24];
        item_events.delete();
        case (cmd)
            CMD_ADC: begin
                for (int k = 0; k < KEYS; k++) begin
                    c = int'(center_q[k]);
                    w = int'(drift_win);
                    if (c == 0) continue;
                    hit_q[k] = (int'(sample) < c + w) && (int'(sample) > c - w);
                    if (level_q[k] != hit_q[k]) armed_q[k] = 1'b1;
                end
            end
            CMD_EDGE: begin
                if (gpio_mask[idx]) begin
                    if (wake_mask[idx] && susp) begin
                        level_q[idx] = 1'b1;
                        add_event(idx, 1'b0, 1'b1);
                    end
                    clear_hold(idx);
                    armed_q[idx] = 1'b1;
                end
            end
            CMD_TICK: begin
                for (int k = 0; k < KEYS; k++) begin
                    if (!armed_q[k]) continue;
                    armed_q[k] = 1'b0;
                    st = gpio_mask[k] ? (lv[k] ^ alow_mask[k]) : hit_q[k];
                    if (long_mask[k]) begin
                        tick_long(k, st);
                    end else begin
                        if (level_q[k] != st) begin
                            level_q[k] = st;
                            add_event(k, 1'b0, st);
                        end
                        if (st) armed_q[k] = 1'b1;
                    end
                end
            end
            default: center_q[idx] = cen;
        endcase
        if (item_events.size() > 0) item_events[item_events.size() - 1].last = 1'b1;
        foreach (item_events[n]) expected_events.push_back(item_events[n]);
    endfunction

    // track registers, predict on input transactions, compare on output ones
    always @(posedge i_clk) begin
        t_key_event exp_ev;
        if (!i_rst_n) begin
            drift_win  = 10'd70;
            long_ticks = 16'd100;
            gap_ticks  = 16'd50;
            gpio_mask  = '0;
            alow_mask  = '0;
            long_mask  = '0;
            wake_mask  = '0;
            for (int k = 0; k < KEYS; k++) begin
                center_q[k] = '0;
                hit_q[k]    = 1'b0;
                level_q[k]  = 1'b0;
                armed_q[k]  = 1'b0;
                held_q[k]   = 1'b0;
                short_q[k]  = 0;
                period_q[k] = 0;
                past_q[k]   = 1'b0;
            end
            expected_events.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[4:2])
                    REG_DRIFT:  drift_win  = i_pwdata[9:0];
                    REG_LONG:   long_ticks = i_pwdata[15:0];
                    REG_GAP:    gap_ticks  = i_pwdata[15:0];
                    REG_GPIO:   gpio_mask  = i_pwdata[7:0];
                    REG_ALOW:   alow_mask  = i_pwdata[7:0];
                    REG_LPMASK: long_mask  = i_pwdata[7:0];
                    REG_WAKE:   wake_mask  = i_pwdata[7:0];
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                o_events_seen++;
                if (expected_events.size() == 0) begin
                    o_errors++;
                    $error("unexpected key event 0x%0h", i_out_data);
                end else begin
                    exp_ev = expected_events.pop_front();
                    if (i_out_data[2:0] !== exp_ev.key) begin
                        o_errors++;
                        $error("event_key: expected %0d, got %0d", exp_ev.key, i_out_data[2:0]);
                    end
                    if (i_out_data[3] !== exp_ev.lng) begin
                        o_errors++;
                        $error("long_code: expected %0b, got %0b", exp_ev.lng, i_out_data[3]);
                    end
                    if (i_out_data[4] !== exp_ev.pr) begin
                        o_errors++;
                        $error("pressed: expected %0b, got %0b", exp_ev.pr, i_out_data[4]);
                    end
                    if (i_out_last !== exp_ev.last) begin
                        o_errors++;
                        $error("last: expected %0b, got %0b", exp_ev.last, i_out_last);
                    end
                end
            end
            if (i_in_valid && i_in_ready) predict_scan(i_in_data);
        end
    end

    initial begin
        o_errors      = 0;
        o_events_seen = 0;
    end

endmodule

@@ verif/tb_top.sv @@
// Top of the key scanner testbench: clock, reset, APB setup and stream stimulus.
// Depends on agks_pkg, agks_checker and adc_gpio_key_scanner_long_press_core.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import agks_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_CYCLES = 24;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic        m_tlast;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    int errors, pending, events_seen;
    int items_sent = 0;
    int cycles = 0;
    int phases_run = 0;
    logic idle_on = 1'b1;

    // stimulus-side copy of the setup, used to shape key sequences
    logic [9:0]  cur_drift;
    logic [15:0] cur_long;
    logic [15:0] cur_gap;
    logic [7:0]  cur_gpio, cur_alow;
    logic [9:0]  cur_center [8];

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    adc_gpio_key_scanner_long_press_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_tvalid), .s_axis_tready(s_tready), .s_axis_tdata(s_tdata),
        .m_axis_tvalid(m_tvalid), .m_axis_tready(m_tready), .m_axis_tdata(m_tdata),
        .m_axis_tlast(m_tlast),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    agks_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(s_tvalid), .i_in_ready(s_tready), .i_in_data(s_tdata),
        .i_out_valid(m_tvalid), .i_out_ready(m_tready), .i_out_data(m_tdata),
        .i_out_last(m_tlast),
        .i_psel(psel), .i_penable(penable), .i_pwrite(pwrite), .i_pready(pready),
        .i_paddr(paddr), .i_pwdata(pwdata),
        .o_errors(errors), .o_pending(pending), .o_events_seen(events_seen)
    );

    // abort on a hang
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // random backpressure on the event stream while idle_on is set
    always @(negedge i_clk) begin
        m_tready <= !idle_on || ($urandom_range(0, 99) >= 36);
    end

    task automatic reg_write(input logic [2:0] index, input logic [31:0] value);
        psel    = 1'b1;
        pwrite  = 1'b1;
        penable = 1'b0;
        paddr   = {index, 2'b00};
        pwdata  = value;
        @(negedge i_clk);
        penable = 1'b1;
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // hold until every event is out and the chain has gone quiet
    task automatic wait_drain();
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic send_item(input logic [1:0] cmd, input logic [9:0] sample,
                             input logic [2:0] idx, input logic [7:0] lv,
                             input logic susp, input logic [9:0] cen);
        if (idle_on && $urandom_range(0, 99) < 36) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge i_clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {6'b0, cen, susp, lv, idx, sample, cmd};
        do @(posedge i_clk); while (!s_tready);
        @(negedge i_clk);
        s_tvalid = 1'b0;
        items_sent++;
        if (cmd == CMD_CENTER) cur_center[idx] = cen;
    endtask

    task automatic send_noise();
        send_item(2'($urandom_range(0, 3)), 10'($urandom), 3'($urandom), 8'($urandom),
                  1'($urandom), 10'($urandom));
    endtask

    task automatic configure(input logic [9:0] drift, input logic [15:0] lp,
                             input logic [15:0] gap, input logic [7:0] gpio,
                             input logic [7:0] alow, input logic [7:0] lpm,
                             input logic [7:0] wake);
        wait_drain();
        reg_write(REG_DRIFT, 32'(drift));
        reg_write(REG_LONG, 32'(lp));
        reg_write(REG_GAP, 32'(gap));
        reg_write(REG_GPIO, 32'(gpio));
        reg_write(REG_ALOW, 32'(alow));
        reg_write(REG_LPMASK, 32'(lpm));
        reg_write(REG_WAKE, 32'(wake));
        cur_drift = drift;
        cur_long  = lp;
        cur_gap   = gap;
        cur_gpio  = gpio;
        cur_alow  = alow;
        phases_run++;
    endtask

    // one press-hold-release on a random key, with random surrounding content
    task automatic key_sequence();
        int         k;
        int         hold;
        int         off;
        logic [7:0] lv;
        logic [9:0] hit;
        k    = $urandom_range(0, 7);
        hold = $urandom_range(1, 12);
        if (cur_gpio[k]) begin
            send_item(CMD_EDGE, 10'($urandom), 3'(k), 8'($urandom), 1'($urandom), 10'($urandom));
            for (int n = 0; n < hold; n++) begin
                lv = 8'($urandom);
                lv[k] = ~cur_alow[k];
                send_item(CMD_TICK, 10'($urandom), 3'($urandom), lv, 1'($urandom), 10'($urandom));
            end
            send_item(CMD_EDGE, 10'($urandom), 3'(k), 8'($urandom), 1'($urandom), 10'($urandom));
            for (int n = 0; n < 2; n++) begin
                lv = 8'($urandom);
                lv[k] = cur_alow[k];
                send_item(CMD_TICK, 10'($urandom), 3'($urandom), lv, 1'($urandom), 10'($urandom));
            end
        end else if (cur_center[k] != 0) begin
            off = (cur_drift > 1) ? $urandom_range(0, cur_drift - 1) : 0;
            hit = ($urandom_range(0, 1) != 0) ? cur_center[k] + 10'(off)
                                              : cur_center[k] - 10'(off);
            for (int n = 0; n < hold; n++) begin
                send_item(CMD_ADC, hit, 3'($urandom), 8'($urandom), 1'($urandom),
                          10'($urandom));
                send_item(CMD_TICK, 10'($urandom), 3'($urandom), 8'($urandom),
                          1'($urandom), 10'($urandom));
            end
            send_item(CMD_ADC, 10'd0, 3'($urandom), 8'($urandom), 1'($urandom), 10'($urandom));
            send_item(CMD_TICK, 10'($urandom), 3'($urandom), 8'($urandom), 1'($urandom),
                      10'($urandom));
        end else begin
            send_noise();
        end
    endtask

    task automatic set_centers();
        for (int k = 0; k < 8; k++)
            send_item(CMD_CENTER, 10'($urandom), 3'(k), 8'($urandom), 1'($urandom),
                      10'(100 + 110 * k + $urandom_range(0, 30)));
    endtask

    task automatic random_phase(input int n_items);
        int stop;
        stop = items_sent + n_items;
        set_centers();
        while (items_sent < stop) begin
            if ($urandom_range(0, 99) < 80) key_sequence();
            else send_noise();
        end
    endtask

    initial begin
        for (int k = 0; k < 8; k++) cur_center[k] = '0;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: window edges, edges on wakeup and non-GPIO keys, long holds
        configure(10'd20, 16'd2, 16'd1, 8'h0F, 8'h05, 8'h3C, 8'h03);
        set_centers();
        send_item(CMD_CENTER, '0, 3'd7, '0, 1'b0, 10'd1023);
        send_item(CMD_ADC, cur_center[4] + 10'd20, '0, '0, 1'b0, '0);
        send_item(CMD_TICK, '0, '0, 8'h00, 1'b0, '0);
        send_item(CMD_ADC, cur_center[4] + 10'd19, '0, '0, 1'b0, '0);
        send_item(CMD_TICK, '0, '0, 8'h00, 1'b0, '0);
        send_item(CMD_ADC, cur_center[4] - 10'd19, '0, '0, 1'b0, '0);
        for (int n = 0; n < 5; n++) send_item(CMD_TICK, '0, '0, 8'hFF, 1'b0, '0);
        send_item(CMD_ADC, 10'd1023, '0, '0, 1'b0, '0);
        send_item(CMD_TICK, '0, '0, 8'hFF, 1'b0, '0);
        send_item(CMD_EDGE, '0, 3'd0, '0, 1'b1, '0);
        send_item(CMD_EDGE, '0, 3'd6, '0, 1'b1, '0);
        send_item(CMD_TICK, '0, '0, 8'hFA, 1'b0, '0);
        send_item(CMD_EDGE, '0, 3'd2, '0, 1'b1, '0);
        send_item(CMD_TICK, '0, '0, 8'h00, 1'b1, '0);
        send_item(CMD_CENTER, '0, 3'd4, '0, 1'b0, 10'd0);
        send_item(CMD_ADC, 10'd0, '0, '0, 1'b0, '0);
        send_item(CMD_TICK, '0, '0, 8'h55, 1'b0, '0);

        // random phases over several setups, extremes included
        random_phase(40);
        configure(10'd0, 16'd0, 16'd0, 8'hF0, 8'hA0, 8'hFF, 8'hF0);
        random_phase(40);
        configure(10'd1023, 16'd65535, 16'd65535, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        random_phase(30);
        configure(10'd40, 16'd1, 16'd65535, 8'h00, 8'h00, 8'hFF, 8'h00);
        idle_on = 1'b0;
        random_phase(50);
        idle_on = 1'b1;
        configure(10'($urandom_range(5, 120)), 16'($urandom_range(1, 4)),
                  16'($urandom_range(0, 3)), 8'($urandom), 8'($urandom), 8'($urandom),
                  8'($urandom));
        random_phase(50);
        // change the hold period under live phases to hit the wrap case
        configure(10'd70, 16'd3, 16'd2, 8'($urandom), 8'($urandom), 8'hFF, 8'($urandom));
        random_phase(50);

        wait_drain();
        $display("Covered %0d input items over %0d register setups, %0d key events checked.",
                 items_sent, phases_run, events_seen);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

@@ files.f @@
src/agks_pkg.sv
src/agks_cell.sv
src/adc_gpio_key_scanner_long_press_core.sv
verif/agks_checker.sv
verif/tb_top.sv
